[sv/tsfifo_pkg.sv]
// shared constants, types and codes for the timestamped request queue
package tsfifo_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;
    localparam int ENTRY_W = 2 * DATA_W;

    typedef enum logic [1:0] {
        FN_ENQ = 2'd0,
        FN_DEQ = 2'd1,
        FN_REM = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_SHIFT,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    set_status;
        t_status status;
        logic    enq;
        logic    start_rd;
        logic    capture;
        logic    shift;
        logic    count_dec;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  pos_ok;
        logic  more;
    } t_dp_stat;

endpackage

[sv/tsfifo_ram.sv]
// generic single write port ram with registered read
module tsfifo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tsfifo_dp.sv]
// datapath: request latches, entry store, count, compaction index and result registers
module tsfifo_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tsfifo_pkg::t_dp_cmd                   i_cmd,
    output tsfifo_pkg::t_dp_stat                  o_stat,
    input  logic [1:0]                            i_func,
    input  logic signed [tsfifo_pkg::DATA_W-1:0]  i_value_in,
    input  logic [tsfifo_pkg::DATA_W-1:0]         i_arrival_stamp,
    input  logic [tsfifo_pkg::CNT_W-1:0]          i_position,
    input  logic [tsfifo_pkg::DATA_W-1:0]         i_now_time,
    output logic signed [tsfifo_pkg::DATA_W-1:0]  o_value_out,
    output logic [tsfifo_pkg::DATA_W-1:0]         o_arrival_out,
    output logic [tsfifo_pkg::DATA_W-1:0]         o_wait_time,
    output logic [1:0]                            o_status,
    output logic [tsfifo_pkg::CNT_W-1:0]          o_occupancy
);
    import tsfifo_pkg::*;

    t_func              r_func;
    logic [DATA_W-1:0]  r_value;
    logic [DATA_W-1:0]  r_stamp;
    logic [CNT_W-1:0]   r_pos;
    logic [DATA_W-1:0]  r_now;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [ADDR_W-1:0]  r_idx;
    logic [ADDR_W-1:0]  n_idx;
    logic [DATA_W-1:0]  r_res_value;
    logic [DATA_W-1:0]  r_res_arrival;
    logic [DATA_W-1:0]  r_res_wait;
    t_status            r_res_status;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ADDR_W-1:0]  first_addr;
    logic [CNT_W-1:0]   idx_plus1;
    logic [DATA_W-1:0]  rd_stamp;

    assign first_addr = (r_func == FN_DEQ) ? '0 : ADDR_W'(r_pos - CNT_W'(1));
    assign idx_plus1  = CNT_W'(r_idx) + CNT_W'(1);
    assign rd_stamp   = ram_rdata[DATA_W-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_raddr = r_idx;
        n_idx     = r_idx;
        n_count   = r_count;
        if (i_cmd.enq) begin
            ram_we    = 1'b1;
            ram_waddr = r_count[ADDR_W-1:0];
            ram_wdata = {r_value, r_stamp};
            n_count   = r_count + CNT_W'(1);
        end
        if (i_cmd.start_rd) begin
            ram_raddr = first_addr;
            n_idx     = first_addr;
        end
        if (i_cmd.capture) begin
            ram_raddr = idx_plus1[ADDR_W-1:0];
        end
        // move entry idx+1 down to idx, fetch the one after it
        if (i_cmd.shift) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx;
            ram_wdata = ram_rdata;
            ram_raddr = r_idx + ADDR_W'(2);
            n_idx     = r_idx + ADDR_W'(1);
        end
        if (i_cmd.count_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    tsfifo_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_func        <= t_func'(i_func);
            r_value       <= i_value_in;
            r_stamp       <= i_arrival_stamp;
            r_pos         <= i_position;
            r_now         <= i_now_time;
            r_res_value   <= '0;
            r_res_arrival <= '0;
            r_res_wait    <= '0;
            r_res_status  <= ST_OK;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.capture) begin
            r_res_value <= ram_rdata[ENTRY_W-1:DATA_W];
            if (r_func == FN_DEQ) begin
                r_res_arrival <= rd_stamp;
                r_res_wait    <= r_now - rd_stamp;
            end
        end
    end

    assign o_stat.func   = r_func;
    assign o_stat.full   = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty  = (r_count == '0);
    assign o_stat.pos_ok = (r_pos != '0) && (r_pos <= r_count);
    assign o_stat.more   = (idx_plus1 < r_count);

    assign o_value_out   = r_res_value;
    assign o_arrival_out = r_res_arrival;
    assign o_wait_time   = r_res_wait;
    assign o_status      = r_res_status;
    assign o_occupancy   = r_count;

endmodule

[sv/tsfifo_ctrl.sv]
// controller: sequences check, read, compaction and result strobe per request
module tsfifo_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  o_done,
    input  tsfifo_pkg::t_dp_stat  i_stat,
    output tsfifo_pkg::t_dp_cmd   o_cmd
);
    import tsfifo_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                case (i_stat.func)
                    FN_ENQ: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.enq = 1'b1;
                        end
                    end
                    FN_DEQ: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else begin
                            o_cmd.start_rd = 1'b1;
                            n_state        = S_READ;
                        end
                    end
                    FN_REM: begin
                        if (!i_stat.pos_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else begin
                            o_cmd.start_rd = 1'b1;
                            n_state        = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
                n_state       = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.more) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

[sv/timestamped_fifo_with_remove_at_top.sv]
// top level of the timestamped request queue with indexed removal
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------------
//  request   | start, busy      | i_func i_value_in i_arrival_stamp i_position i_now_time
//  result    | o_done (strobe)  | o_value_out o_arrival_out o_wait_time o_status o_occupancy
//
// a request is taken when start is high and busy is low; one result follows
// enqueue, errors, unused code: check, then done; a new request waits until busy falls
// dequeue / remove-at at p (1 for dequeue) with n entries held: check, read, then shift
// with one-entry-per-cycle compaction of the n - p entries behind p, then done
// synchronous active-low reset empties the queue, entries are not cleared
// o_done lasts one cycle and cannot be held off by the receiver
module timestamped_fifo_with_remove_at_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_func,
    input  logic signed [tsfifo_pkg::DATA_W-1:0]  i_value_in,
    input  logic [tsfifo_pkg::DATA_W-1:0]         i_arrival_stamp,
    input  logic [tsfifo_pkg::CNT_W-1:0]          i_position,
    input  logic [tsfifo_pkg::DATA_W-1:0]         i_now_time,
    output logic                                  o_done,
    output logic signed [tsfifo_pkg::DATA_W-1:0]  o_value_out,
    output logic [tsfifo_pkg::DATA_W-1:0]         o_arrival_out,
    output logic [tsfifo_pkg::DATA_W-1:0]         o_wait_time,
    output logic [1:0]                            o_status,
    output logic [tsfifo_pkg::CNT_W-1:0]          o_occupancy
);
    import tsfifo_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    tsfifo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    tsfifo_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_func          (i_func),
        .i_value_in      (i_value_in),
        .i_arrival_stamp (i_arrival_stamp),
        .i_position      (i_position),
        .i_now_time      (i_now_time),
        .o_value_out     (o_value_out),
        .o_arrival_out   (o_arrival_out),
        .o_wait_time     (o_wait_time),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_occupancy <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe longer than one cycle");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_FULL |-> o_occupancy == CNT_W'(DEPTH))
        else $error("full reported with free slots");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_value_out == '0 && o_wait_time == '0)
        else $error("error result carries data");
`endif

endmodule
